@@ sv/swarq_pkg.sv @@
// Shared types and constants for the sliding-window ARQ sender.
package swarq_pkg;

  localparam int WINDOW_MAX_DEF = 16;
  localparam int TIME_BITS_DEF  = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAME_W    = 16;
  localparam int SLOTS_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SLOTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES  = 2'd2;

  localparam logic [SLOTS_W-1:0] WINDOW_SLOTS_RST  = 5'd4;
  localparam logic [FRAME_W-1:0] TIMEOUT_TICKS_RST = 16'd5000;
  localparam logic [FRAME_W-1:0] TOTAL_FRAMES_RST  = 16'd10;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_ACK  = 1'b1;

  typedef struct packed {
    logic shift;
    logic ack_we;
    logic mark_we;
  } slot_ctl_t;

endpackage

@@ sv/swarq_slots.sv @@
// Window slot store: acknowledged and sent marks and send stamps, with a one-slot shift.
module swarq_slots #(
  parameter int WINDOW_MAX = swarq_pkg::WINDOW_MAX_DEF,
  parameter int TIME_BITS  = swarq_pkg::TIME_BITS_DEF,
  parameter int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  parameter int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  swarq_pkg::slot_ctl_t    ctl,
  input  logic [CNT_W-1:0]        live,
  input  logic [IDX_W-1:0]        ack_idx,
  input  logic [IDX_W-1:0]        rd_idx,
  input  logic [TIME_BITS-1:0]    time_now,
  output logic                    head_acked,
  output logic                    rd_acked,
  output logic                    rd_sent,
  output logic [TIME_BITS-1:0]    rd_stamp
);

  logic [WINDOW_MAX-1:0] acked_r;
  logic [WINDOW_MAX-1:0] sent_r;
  logic [TIME_BITS-1:0]  stamp_r [WINDOW_MAX];

  assign head_acked = acked_r[0];
  assign rd_acked   = acked_r[rd_idx];
  assign rd_sent    = sent_r[rd_idx];
  assign rd_stamp   = stamp_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acked_r <= '0;
      sent_r  <= '0;
    end else if (ctl.shift) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        if (CNT_W'(i + 1) < live) begin
          acked_r[i] <= acked_r[(i + 1) % WINDOW_MAX];
          sent_r[i]  <= sent_r[(i + 1) % WINDOW_MAX];
        end else if (CNT_W'(i + 1) == live) begin
          acked_r[i] <= 1'b0;
          sent_r[i]  <= 1'b0;
        end
      end
    end else if (ctl.ack_we) begin
      acked_r[ack_idx] <= 1'b1;
    end else if (ctl.mark_we) begin
      sent_r[rd_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        if (CNT_W'(i + 1) < live) begin
          stamp_r[i] <= stamp_r[(i + 1) % WINDOW_MAX];
        end
      end
    end else if (ctl.mark_we) begin
      stamp_r[rd_idx] <= time_now;
    end
  end

endmodule

@@ sv/swarq_seq.sv @@
// Sequencer: time counter, window base, slide and scan steps, and the send order register.
module swarq_seq #(
  parameter int WINDOW_MAX = swarq_pkg::WINDOW_MAX_DEF,
  parameter int TIME_BITS  = swarq_pkg::TIME_BITS_DEF,
  parameter int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  parameter int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             in_action,
  input  logic [swarq_pkg::FRAME_W-1:0]    in_ack_frame,
  input  logic [CNT_W-1:0]                 live,
  input  logic [swarq_pkg::FRAME_W-1:0]    timeout_ticks,
  input  logic [swarq_pkg::FRAME_W-1:0]    total_frames,
  input  logic                             head_acked,
  input  logic                             rd_acked,
  input  logic                             rd_sent,
  input  logic [TIME_BITS-1:0]             rd_stamp,
  output swarq_pkg::slot_ctl_t             ctl,
  output logic [IDX_W-1:0]                 ack_idx,
  output logic [IDX_W-1:0]                 rd_idx,
  output logic [TIME_BITS-1:0]             time_now,
  output logic                             busy,
  output logic                             out_valid,
  output logic [swarq_pkg::FRAME_W-1:0]    out_frame_id,
  output logic                             out_is_resend,
  output logic                             out_last
);

  localparam int EL_W = (TIME_BITS > swarq_pkg::FRAME_W) ? TIME_BITS : swarq_pkg::FRAME_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SLIDE, ST_SCAN, ST_FLUSH} state_t;

  state_t                          state_r;
  logic [swarq_pkg::FRAME_W-1:0]   base_r;
  logic [TIME_BITS-1:0]            time_r;
  logic [IDX_W-1:0]                idx_r;
  logic                            pend_v_r;
  logic [swarq_pkg::FRAME_W-1:0]   pend_frame_r;
  logic                            pend_resend_r;
  logic                            out_valid_r;
  logic [swarq_pkg::FRAME_W-1:0]   out_frame_r;
  logic                            out_resend_r;
  logic                            out_last_r;

  logic                            accept;
  logic [swarq_pkg::FRAME_W-1:0]   ack_off;
  logic [swarq_pkg::FRAME_W:0]     frame_sum;
  logic                            in_range;
  logic [TIME_BITS-1:0]            elapsed;
  logic                            lost;
  logic                            hit;
  logic                            idx_last;

  assign accept    = start && (state_r == ST_IDLE);
  assign ack_off   = in_ack_frame - base_r;
  assign ack_idx   = ack_off[IDX_W-1:0];
  assign rd_idx    = idx_r;
  assign time_now  = time_r;
  assign busy      = (state_r != ST_IDLE);

  assign frame_sum = {1'b0, base_r} + (swarq_pkg::FRAME_W + 1)'(idx_r);
  assign in_range  = !frame_sum[swarq_pkg::FRAME_W] &&
                     (frame_sum[swarq_pkg::FRAME_W-1:0] < total_frames);
  assign elapsed   = time_r - rd_stamp;
  assign lost      = !rd_acked && (EL_W'(elapsed) > EL_W'(timeout_ticks));
  assign hit       = (state_r == ST_SCAN) && in_range && (!rd_sent || lost);
  assign idx_last  = (CNT_W'(idx_r) == live - CNT_W'(1));

  assign ctl.shift   = (state_r == ST_SLIDE) && head_acked;
  assign ctl.ack_we  = accept && (in_action == swarq_pkg::ACT_ACK) &&
                       (ack_off < swarq_pkg::FRAME_W'(live));
  assign ctl.mark_we = hit;

  assign out_valid     = out_valid_r;
  assign out_frame_id  = out_frame_r;
  assign out_is_resend = out_resend_r;
  assign out_last      = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      time_r      <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_action == swarq_pkg::ACT_TICK)) begin
            time_r  <= time_r + TIME_BITS'(1);
            state_r <= ST_SLIDE;
          end
        end
        ST_SLIDE: begin
          if (head_acked) begin
            base_r <= base_r + swarq_pkg::FRAME_W'(1);
          end else begin
            idx_r    <= '0;
            pend_v_r <= 1'b0;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            if (pend_v_r) begin
              out_valid_r  <= 1'b1;
              out_frame_r  <= pend_frame_r;
              out_resend_r <= pend_resend_r;
              out_last_r   <= 1'b0;
            end
            pend_v_r      <= 1'b1;
            pend_frame_r  <= frame_sum[swarq_pkg::FRAME_W-1:0];
            pend_resend_r <= rd_sent;
          end
          idx_r <= idx_r + IDX_W'(1);
          if (idx_last) begin
            state_r <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (pend_v_r) begin
            out_valid_r  <= 1'b1;
            out_frame_r  <= pend_frame_r;
            out_resend_r <= pend_resend_r;
            out_last_r   <= 1'b1;
          end
          pend_v_r <= 1'b0;
          state_r  <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ sv/sliding_window_arq_sender.sv @@
// Top level of the selective-repeat ARQ sender window: configuration registers and wiring.
//
//   Channel  Ports                                   Handshake
//   input    in_action, in_ack_frame                 accepted when start high and busy low
//   result   out_frame_id, out_is_resend, out_last   one cycle per send order on out_valid
//   config   cfg_index, cfg_data                     written when cfg_we is high
//
// An acknowledgement transaction is taken and busy stays low. A tick keeps busy high in
// the slide state, which shifts out the run of acknowledged slots at the window start, the
// scan state, which visits each window slot through the shared elapsed-time comparator at
// one slot a cycle, and the flush state, which releases the final order. That order is
// on the result ports in the cycle in which busy goes low; the receiver cannot stall.
// Reset is synchronous and clears all marks at once, with no clearing pass.
module sliding_window_arq_sender #(
  parameter int WINDOW_MAX = swarq_pkg::WINDOW_MAX_DEF,
  parameter int TIME_BITS  = swarq_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_action,
  input  logic [swarq_pkg::FRAME_W-1:0]     in_ack_frame,
  output logic                              out_valid,
  output logic [swarq_pkg::FRAME_W-1:0]     out_frame_id,
  output logic                              out_is_resend,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [swarq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swarq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  logic [swarq_pkg::SLOTS_W-1:0]  window_slots_r;
  logic [swarq_pkg::FRAME_W-1:0]  timeout_ticks_r;
  logic [swarq_pkg::FRAME_W-1:0]  total_frames_r;

  logic [CNT_W-1:0]        live;
  swarq_pkg::slot_ctl_t    ctl;
  logic [IDX_W-1:0]        ack_idx;
  logic [IDX_W-1:0]        rd_idx;
  logic [TIME_BITS-1:0]    time_now;
  logic                    head_acked;
  logic                    rd_acked;
  logic                    rd_sent;
  logic [TIME_BITS-1:0]    rd_stamp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_slots_r  <= swarq_pkg::WINDOW_SLOTS_RST;
      timeout_ticks_r <= swarq_pkg::TIMEOUT_TICKS_RST;
      total_frames_r  <= swarq_pkg::TOTAL_FRAMES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swarq_pkg::REG_WINDOW_SLOTS:  window_slots_r  <= cfg_data[swarq_pkg::SLOTS_W-1:0];
        swarq_pkg::REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data;
        swarq_pkg::REG_TOTAL_FRAMES:  total_frames_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (window_slots_r == '0) begin
      live = CNT_W'(1);
    end else if (9'(window_slots_r) > 9'(WINDOW_MAX)) begin
      live = CNT_W'(WINDOW_MAX);
    end else begin
      live = CNT_W'(window_slots_r);
    end
  end

  swarq_slots #(
    .WINDOW_MAX (WINDOW_MAX),
    .TIME_BITS  (TIME_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_slots (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .live       (live),
    .ack_idx    (ack_idx),
    .rd_idx     (rd_idx),
    .time_now   (time_now),
    .head_acked (head_acked),
    .rd_acked   (rd_acked),
    .rd_sent    (rd_sent),
    .rd_stamp   (rd_stamp)
  );

  swarq_seq #(
    .WINDOW_MAX (WINDOW_MAX),
    .TIME_BITS  (TIME_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_action        (in_action),
    .in_ack_frame     (in_ack_frame),
    .live             (live),
    .timeout_ticks    (timeout_ticks_r),
    .total_frames     (total_frames_r),
    .head_acked       (head_acked),
    .rd_acked         (rd_acked),
    .rd_sent          (rd_sent),
    .rd_stamp         (rd_stamp),
    .ctl              (ctl),
    .ack_idx          (ack_idx),
    .rd_idx           (rd_idx),
    .time_now         (time_now),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_frame_id     (out_frame_id),
    .out_is_resend    (out_is_resend),
    .out_last         (out_last)
  );

endmodule

@@ sv/swarq_chk.sv @@
// Port-level checker for the ARQ sender window, bound to the top level.
module swarq_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_action,
  input logic out_valid,
  input logic out_last
);

  a_ack_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == swarq_pkg::ACT_ACK) |=> !busy)
    else $error("Acknowledgement transaction made the block busy.");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == swarq_pkg::ACT_TICK) |=> busy)
    else $error("Tick transaction did not start work.");

  a_out_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("Send order appeared outside a tick.");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("Non-final send order while the block is idle.");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("Send order followed the final one.");

endmodule

bind sliding_window_arq_sender swarq_chk u_swarq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_action (in_action),
  .out_valid (out_valid),
  .out_last  (out_last)
);
